@@ rtl/core/assert_macros.svh @@
// Assertion macros for the checker in swpec_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/swpec_pkg.sv @@
package swpec_pkg;

  localparam int unsigned RING_DEPTH_DEF = 1024;

  localparam int unsigned TIME_W  = 25;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned SEC_W   = 6;

  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MONTHS        = 12;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(3600);

  localparam logic [3*CHAR_W-1:0] MONTH_NAME [MONTHS] = '{
    24'h4A616E, 24'h466562, 24'h4D6172, 24'h417072, 24'h4D6179, 24'h4A756E,
    24'h4A756C, 24'h417567, 24'h536570, 24'h4F6374, 24'h4E6F76, 24'h446563
  };

  localparam logic [TIME_W-1:0] MONTH_OFFSET [MONTHS] = '{
    25'd0,        25'd2678400,  25'd5097600,  25'd7776000,
    25'd10368000, 25'd13046400, 25'd15638400, 25'd18316800,
    25'd20995200, 25'd23587200, 25'd26265600, 25'd28857600
  };

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic load;
    logic drop;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic occ_empty;
    logic expired;
    logic out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic [DAY_W-1:0]  day_of_month;
    logic [CHAR_W-1:0] month_char_a;
    logic [CHAR_W-1:0] month_char_b;
    logic [CHAR_W-1:0] month_char_c;
    logic [HOUR_W-1:0] hour_value;
    logic [MIN_W-1:0]  minute_value;
    logic [SEC_W-1:0]  second_value;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0]  event_time;
    logic [COUNT_W-1:0] window_count;
    logic [COUNT_W-1:0] best_count;
    logic [INDEX_W-1:0] best_first_index;
    logic [INDEX_W-1:0] best_last_index;
    logic               overflowed;
  } out_word_t;

  localparam int unsigned OUT_WORD_W = $bits(out_word_t);

  function automatic logic [TIME_W-1:0] event_seconds(input in_word_t w);
    logic [TIME_W-1:0] off;
    logic [DAY_W-1:0]  day0;
    off = '0;
    for (int i = 0; i < MONTHS; i++) begin
      if ({w.month_char_a, w.month_char_b, w.month_char_c} == MONTH_NAME[i]) begin
        off = MONTH_OFFSET[i];
      end
    end
    day0 = (w.day_of_month == '0) ? '0 : w.day_of_month - DAY_W'(1);
    return off
         + TIME_W'(day0) * TIME_W'(SECS_PER_DAY)
         + TIME_W'(w.hour_value) * TIME_W'(SECS_PER_HOUR)
         + TIME_W'(w.minute_value) * TIME_W'(SECS_PER_MIN)
         + TIME_W'(w.second_value);
  endfunction

endpackage

@@ rtl/core/swpec_if.sv @@
interface swpec_in_if;
  import swpec_pkg::*;

  logic              valid;
  logic              ready;
  logic [DAY_W-1:0]  day_of_month;
  logic [CHAR_W-1:0] month_char_a;
  logic [CHAR_W-1:0] month_char_b;
  logic [CHAR_W-1:0] month_char_c;
  logic [HOUR_W-1:0] hour_value;
  logic [MIN_W-1:0]  minute_value;
  logic [SEC_W-1:0]  second_value;

  modport source (
    output valid, day_of_month, month_char_a, month_char_b, month_char_c,
           hour_value, minute_value, second_value,
    input  ready
  );

  modport sink (
    input  valid, day_of_month, month_char_a, month_char_b, month_char_c,
           hour_value, minute_value, second_value,
    output ready
  );
endinterface

interface swpec_out_if;
  import swpec_pkg::*;

  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  event_time;
  logic [COUNT_W-1:0] window_count;
  logic [COUNT_W-1:0] best_count;
  logic [INDEX_W-1:0] best_first_index;
  logic [INDEX_W-1:0] best_last_index;
  logic               overflowed;

  modport source (
    output valid, event_time, window_count, best_count, best_first_index,
           best_last_index, overflowed,
    input  ready
  );

  modport sink (
    input  valid, event_time, window_count, best_count, best_first_index,
           best_last_index, overflowed,
    output ready
  );
endinterface

interface swpec_cfg_if;
  import swpec_pkg::*;

  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] window_seconds;

  modport source (
    output valid, window_seconds,
    input  ready
  );

  modport sink (
    input  valid, window_seconds,
    output ready
  );
endinterface

@@ rtl/core/sliding_window_peak_event_count_unit.sv @@
// Sliding-window peak event counter. Each input word is a log timestamp (day, three-letter
// month name, hour, minute, second) that is turned into seconds from the start of a non-leap
// year; an unknown month name counts as January. The time goes into a ring of RING_DEPTH
// entries, entries older than window_seconds are aged out, and each input word produces one
// result word with the time, the current window count, the best count so far and the item
// indices of that best window. When the ring is full the oldest entry is evicted and the
// sticky overflowed flag is set. One word is processed at a time, and each entry that
// ages out of the window costs one read of the ring memory's single read port. A result
// waits in an output register, so a new word is accepted while the previous result is
// still pending; a third word waits only if that result has not been taken. The ring
// needs no clearing after reset, and the configuration port is always ready.
module sliding_window_peak_event_count_unit #(
  parameter int unsigned RING_DEPTH = swpec_pkg::RING_DEPTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  swpec_in_if.sink    in_ch,
  swpec_out_if.source out_ch,
  swpec_cfg_if.sink   cfg_ch
);
  import swpec_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  in_word_t  in_word;
  out_word_t out_word;
  logic      in_ready;
  logic      out_valid;

  assign in_word.day_of_month = in_ch.day_of_month;
  assign in_word.month_char_a = in_ch.month_char_a;
  assign in_word.month_char_b = in_ch.month_char_b;
  assign in_word.month_char_c = in_ch.month_char_c;
  assign in_word.hour_value   = in_ch.hour_value;
  assign in_word.minute_value = in_ch.minute_value;
  assign in_word.second_value = in_ch.second_value;

  swpec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swpec_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.window_seconds),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_word  (out_word)
  );

  assign in_ch.ready             = in_ready;
  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid;
  assign out_ch.event_time       = out_word.event_time;
  assign out_ch.window_count     = out_word.window_count;
  assign out_ch.best_count       = out_word.best_count;
  assign out_ch.best_first_index = out_word.best_first_index;
  assign out_ch.best_last_index  = out_word.best_last_index;
  assign out_ch.overflowed       = out_word.overflowed;

endmodule

@@ rtl/core/swpec_ram.sv @@
module swpec_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/swpec_ctrl.sv @@
module swpec_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swpec_pkg::dp_stat_t stat,
  output swpec_pkg::dp_cmd_t  cmd
);
  import swpec_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   aged;

  assign aged = !stat.occ_empty && stat.expired;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!aged && !stat.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.drop   = aged;
        cmd.commit = !aged && !stat.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/core/swpec_dp.sv @@
module swpec_dp #(
  parameter int unsigned RING_DEPTH = swpec_pkg::RING_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  swpec_pkg::dp_cmd_t               cmd,
  output swpec_pkg::dp_stat_t              stat,
  input  swpec_pkg::in_word_t              in_word,
  input  logic                             cfg_we,
  input  logic [swpec_pkg::TIME_W-1:0]     cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output swpec_pkg::out_word_t             out_word
);
  import swpec_pkg::*;

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned OCC_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(RING_DEPTH);

  logic [TIME_W-1:0]  time_r, time_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [INDEX_W-1:0] idx_r, idx_nxt;
  logic [OCC_W-1:0]   best_span_r, best_span_nxt;
  logic [INDEX_W-1:0] best_start_r, best_start_nxt;
  logic [INDEX_W-1:0] best_end_r, best_end_nxt;
  logic               ovf_r, ovf_nxt;
  logic [TIME_W-1:0]  win_r, win_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic [TIME_W-1:0]  old_time;
  logic [TIME_W:0]    diff;
  logic               full;
  logic [OCC_W-1:0]   occ_new;
  logic [OCC_W-1:0]   occ_m1;
  logic [PTR_W-1:0]   ptr_adv;

  swpec_ram #(
    .WIDTH (TIME_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (cmd.commit),
    .wr_addr (wr_ptr_r),
    .wr_data (time_r),
    .rd_addr (ptr_nxt),
    .rd_data (old_time)
  );

  assign diff           = {1'b0, time_r} - {1'b0, old_time};
  assign stat.expired   = !diff[TIME_W] && (diff[TIME_W-1:0] > win_r);
  assign stat.occ_empty = (occ_r == '0);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign full    = (occ_r == FULL_OCC);
  assign occ_new = full ? occ_r : occ_r + OCC_W'(1);
  assign occ_m1  = full ? occ_r - OCC_W'(1) : occ_r;
  assign ptr_adv = (ptr_r == LAST_PTR) ? '0 : ptr_r + PTR_W'(1);

  always_comb begin
    time_nxt       = time_r;
    ptr_nxt        = ptr_r;
    wr_ptr_nxt     = wr_ptr_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    best_span_nxt  = best_span_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    ovf_nxt        = ovf_r;
    win_nxt        = cfg_we ? cfg_data : win_r;
    out_word_nxt   = out_word_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (cmd.load) begin
      time_nxt = event_seconds(in_word);
    end

    if (cmd.drop) begin
      ptr_nxt = ptr_adv;
      occ_nxt = occ_r - OCC_W'(1);
    end

    if (cmd.commit) begin
      if (full) begin
        ptr_nxt = ptr_adv;
        ovf_nxt = 1'b1;
      end
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      occ_nxt    = occ_new;
      idx_nxt    = idx_r + INDEX_W'(1);
      if (occ_new > best_span_r) begin
        best_span_nxt  = occ_new;
        best_start_nxt = idx_r - INDEX_W'(occ_m1);
        best_end_nxt   = idx_r;
      end
      out_word_nxt.event_time       = time_r;
      out_word_nxt.window_count     = COUNT_W'(occ_new);
      out_word_nxt.best_count       = COUNT_W'(best_span_nxt);
      out_word_nxt.best_first_index = best_start_nxt;
      out_word_nxt.best_last_index  = best_end_nxt;
      out_word_nxt.overflowed       = ovf_nxt;
      out_valid_nxt                 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r        <= '0;
      wr_ptr_r     <= '0;
      occ_r        <= '0;
      idx_r        <= '0;
      best_span_r  <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      ovf_r        <= 1'b0;
      win_r        <= WINDOW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      ptr_r        <= ptr_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      occ_r        <= occ_nxt;
      idx_r        <= idx_nxt;
      best_span_r  <= best_span_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      ovf_r        <= ovf_nxt;
      win_r        <= win_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    time_r     <= time_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

@@ rtl/core/swpec_chk.sv @@
`include "assert_macros.svh"

module swpec_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [swpec_pkg::OUT_WORD_W-1:0] out_data,
  input logic                             out_overflowed
);
  import swpec_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "Stalled result word changed or dropped.")
  `ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "Input accepted while a word is still being processed.")
  `ASSERT_IMPL(a_result_after_work, clk, rst_n, $rose(out_valid), !$past(in_ready), "Result word appeared without a word in process.")
  `ASSERT_NEXT(a_overflow_sticky, clk, rst_n, out_valid && out_overflowed, !out_valid || out_overflowed, "Overflow flag cleared after being set.")

endmodule

bind sliding_window_peak_event_count_unit swpec_chk u_swpec_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_data       ({out_ch.event_time, out_ch.window_count, out_ch.best_count,
                    out_ch.best_first_index, out_ch.best_last_index, out_ch.overflowed}),
  .out_overflowed (out_ch.overflowed)
);

@@ sim/sliding_window_peak_event_count_unit_tb.sv @@
`timescale 1ns / 100ps

module sliding_window_peak_event_count_unit_tb;
  import swpec_pkg::*;

  localparam int unsigned RING        = RING_DEPTH_DEF;
  localparam int unsigned YEAR_SECS   = 31536000;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam logic [TIME_W-1:0] WINDOW_MAX = '1;

  typedef struct packed {
    in_word_t  stim;
    logic      typed;
    out_word_t want;
  } directed_row_t;

  // The first four rows carry results worked out by hand; the rest go through the predictor.
  localparam int unsigned DIRECTED_COUNT = 23;
  localparam directed_row_t DIRECTED_WORDS [DIRECTED_COUNT] = '{
    '{'{5'd1, "J", "a", "n", 5'd0, 6'd0, 6'd0}, 1'b1,
      '{25'd0, 11'd1, 11'd1, 32'd0, 32'd0, 1'b0}},
    '{'{5'd0, "J", "a", "n", 5'd0, 6'd0, 6'd0}, 1'b1,
      '{25'd0, 11'd2, 11'd2, 32'd0, 32'd1, 1'b0}},
    '{'{5'd31, "D", "e", "c", 5'd23, 6'd59, 6'd59}, 1'b1,
      '{25'd31535999, 11'd1, 11'd2, 32'd0, 32'd1, 1'b0}},
    '{'{5'd31, "x", "y", "z", 5'd31, 6'd63, 6'd63}, 1'b1,
      '{25'd2707443, 11'd2, 11'd2, 32'd0, 32'd1, 1'b0}},
    '{'{5'd15, "J", "a", "n", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd28, "F", "e", "b", 5'd23, 6'd59, 6'd59}, 1'b0, '0},
    '{'{5'd1, "M", "a", "r", 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "A", "p", "r", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "M", "a", "y", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "J", "u", "n", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "J", "u", "l", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "A", "u", "g", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "S", "e", "p", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "O", "c", "t", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "N", "o", "v", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "D", "e", "c", 5'd12, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd1, "j", "a", "n", 5'd0, 6'd0, 6'd1}, 1'b0, '0},
    '{'{5'd1, "J", "A", "N", 5'd0, 6'd0, 6'd1}, 1'b0, '0},
    '{'{5'd0, 8'h00, 8'h00, 8'h00, 5'd0, 6'd0, 6'd0}, 1'b0, '0},
    '{'{5'd31, 8'hFF, 8'hFF, 8'hFF, 5'd31, 6'd63, 6'd63}, 1'b0, '0},
    '{'{5'd31, "D", "e", "c", 5'd23, 6'd59, 6'd59}, 1'b0, '0},
    '{'{5'd31, "D", "e", "c", 5'd23, 6'd59, 6'd59}, 1'b0, '0},
    '{'{5'd2, "J", "u", "x", 5'd1, 6'd2, 6'd3}, 1'b0, '0}
  };

  logic clk;
  logic rst_n;

  swpec_in_if  in_ch();
  swpec_out_if out_ch();
  swpec_cfg_if cfg_ch();

  sliding_window_peak_event_count_unit #(
    .RING_DEPTH(RING)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [TIME_W-1:0] held_times [RING];
  int unsigned       head_slot;
  int unsigned       held_count;
  bit [31:0]         word_index;
  int unsigned       peak_span;
  bit [31:0]         peak_first;
  bit [31:0]         peak_last;
  bit                ring_overflowed;
  logic [TIME_W-1:0] window_limit;

  out_word_t   pending_results [$];
  out_word_t   oldest_result;
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned stamp_now;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [TIME_W-1:0] stamp_seconds(input in_word_t w);
    int unsigned offset;
    int unsigned day;
    offset = 0;
    for (int i = 0; i < MONTHS; i++) begin
      if ({w.month_char_a, w.month_char_b, w.month_char_c} == MONTH_NAME[i]) begin
        offset = MONTH_OFFSET[i];
      end
    end
    day = (w.day_of_month == '0) ? 1 : w.day_of_month;
    return TIME_W'(offset + (day - 1) * SECS_PER_DAY + w.hour_value * SECS_PER_HOUR
                   + w.minute_value * SECS_PER_MIN + w.second_value);
  endfunction

  function automatic out_word_t track_peak_window(input in_word_t w);
    out_word_t         r;
    logic [TIME_W-1:0] t;
    int unsigned       slot;
    t = stamp_seconds(w);
    while (held_count > 0 &&
           longint'(t) - longint'(held_times[head_slot]) > longint'(window_limit)) begin
      head_slot = (head_slot + 1) % RING;
      held_count--;
    end
    if (held_count >= RING) begin
      head_slot = (head_slot + 1) % RING;
      held_count--;
      ring_overflowed = 1'b1;
    end
    slot = (head_slot + held_count) % RING;
    held_times[slot] = t;
    held_count++;
    if (held_count > peak_span) begin
      peak_span  = held_count;
      peak_first = word_index - (held_count - 1);
      peak_last  = word_index;
    end
    r.event_time       = t;
    r.window_count     = COUNT_W'(held_count);
    r.best_count       = COUNT_W'(peak_span);
    r.best_first_index = peak_first;
    r.best_last_index  = peak_last;
    r.overflowed       = ring_overflowed;
    word_index++;
    return r;
  endfunction

  function automatic in_word_t word_at(input int unsigned secs);
    in_word_t    w;
    int unsigned m;
    int unsigned rest;
    m = 0;
    for (int i = 1; i < MONTHS; i++) begin
      if (secs >= MONTH_OFFSET[i]) begin
        m = i;
      end
    end
    rest = secs - MONTH_OFFSET[m];
    {w.month_char_a, w.month_char_b, w.month_char_c} = MONTH_NAME[m];
    w.day_of_month = DAY_W'(rest / SECS_PER_DAY + 1);
    rest = rest % SECS_PER_DAY;
    w.hour_value   = HOUR_W'(rest / SECS_PER_HOUR);
    w.minute_value = MIN_W'((rest % SECS_PER_HOUR) / SECS_PER_MIN);
    w.second_value = SEC_W'(rest % SECS_PER_MIN);
    return w;
  endfunction

  // Mostly a clock that moves forward in steps, with jumps, steps back and raw noise words.
  function automatic in_word_t random_word(input int unsigned step_max);
    logic [63:0] noise;
    int unsigned pick;
    int unsigned back;
    pick = $urandom_range(99);
    if (pick < 12) begin
      noise = {$urandom, $urandom};
      return noise[$bits(in_word_t)-1:0];
    end
    if (pick < 16) begin
      back = $urandom_range(0, 4 * step_max + 1);
      stamp_now = stamp_now - ((stamp_now < back) ? stamp_now : back);
    end else if (pick < 20) begin
      stamp_now = stamp_now + $urandom_range(0, 100000);
    end else begin
      stamp_now = stamp_now + $urandom_range(0, step_max);
    end
    if (stamp_now >= YEAR_SECS) begin
      stamp_now = $urandom_range(0, 1000);
    end
    return word_at(stamp_now);
  endfunction

  task automatic send_word(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.day_of_month <= w.day_of_month;
    in_ch.month_char_a <= w.month_char_a;
    in_ch.month_char_b <= w.month_char_b;
    in_ch.month_char_c <= w.month_char_c;
    in_ch.hour_value   <= w.hour_value;
    in_ch.minute_value <= w.minute_value;
    in_ch.second_value <= w.second_value;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = track_peak_window(w);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_window(input logic [TIME_W-1:0] value);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.window_seconds <= value;
    @(posedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
    end
    window_limit = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random(input logic [TIME_W-1:0] window, input int unsigned gap,
                            input int unsigned stall, input int unsigned count,
                            input int unsigned step_max);
    wait_drained();
    write_window(window);
    gap_pct   = gap;
    stall_pct = stall;
    for (int unsigned i = 0; i < count; i++) begin
      send_word(random_word(step_max), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_seen, want, got);
      end
    end
  endtask

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d arrived with nothing expected: time %0d, count %0d",
                   results_seen, out_ch.event_time, out_ch.window_count);
        end
      end else begin
        oldest_result = pending_results.pop_front();
        compare_field("event_time", oldest_result.event_time, out_ch.event_time);
        compare_field("window_count", oldest_result.window_count, out_ch.window_count);
        compare_field("best_count", oldest_result.best_count, out_ch.best_count);
        compare_field("best_first_index", oldest_result.best_first_index,
                      out_ch.best_first_index);
        compare_field("best_last_index", oldest_result.best_last_index,
                      out_ch.best_last_index);
        compare_field("overflowed", oldest_result.overflowed, out_ch.overflowed);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[sliding_window_peak_event_count_unit] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.day_of_month    = '0;
    in_ch.month_char_a    = '0;
    in_ch.month_char_b    = '0;
    in_ch.month_char_c    = '0;
    in_ch.hour_value      = '0;
    in_ch.minute_value    = '0;
    in_ch.second_value    = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.window_seconds = '0;
    head_slot             = 0;
    held_count            = 0;
    word_index            = '0;
    peak_span             = 0;
    peak_first            = '0;
    peak_last             = '0;
    ring_overflowed       = 1'b0;
    window_limit          = WINDOW_RESET;
    mismatches            = 0;
    results_seen          = 0;
    quiet_cycles          = 0;
    gap_pct               = 0;
    stall_pct             = 0;
    stamp_now             = 0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_word(DIRECTED_WORDS[i].stim, DIRECTED_WORDS[i].typed, DIRECTED_WORDS[i].want);
    end
    in_ch.valid <= 1'b0;

    // A zero window ages out head entries with earlier times; the full window fills the ring.
    run_random('0, 77, 0, 150, 1);
    run_random(WINDOW_MAX, 0, 77, 1100, 3000);
    run_random(TIME_W'(300), 19, 19, 100, 60);
    run_random(TIME_W'(86400), 0, 0, 80, 5000);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sliding_window_peak_event_count_unit] OK");
    end else begin
      $display("[sliding_window_peak_event_count_unit] ERROR");
    end
    $finish;
  end

endmodule
